// ===== sv/tlg_pkg.sv =====
// Shared types and constants for the toroidal life grid.
`timescale 1ns / 1ps
package tlg_pkg;

  localparam int DEF_MAX_COLS = 64;
  localparam int DEF_MAX_ROWS = 64;

  localparam int FUNC_W = 2;
  localparam int ROW_W  = 6;
  localparam int COL_W  = 6;
  localparam int CFG_W  = 7;
  localparam int CFG_IDX_W = 1;
  localparam int NBR_W  = 4;

  localparam logic [CFG_W-1:0] CFG_SIZE_RESET = 7'd30;

  localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT = 1'b1;

  localparam logic [FUNC_W-1:0] FUNC_WRITE = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_STEP  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd2;

  localparam logic [NBR_W-1:0] BIRTH_COUNT   = 4'd3;
  localparam logic [NBR_W-1:0] SURVIVE_COUNT = 4'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RMW,
    ST_READ,
    ST_LD_PREV,
    ST_LD_FIRST,
    ST_LD_CUR,
    ST_SWEEP
  } state_e;

endpackage

// ===== sv/tlg_row_mem.sv =====
// Row memory of the cell grid with per-row valid bits cleared at reset.
`timescale 1ns / 1ps
module tlg_row_mem
  import tlg_pkg::*;
#(
  parameter int MAX_COLS = DEF_MAX_COLS,
  parameter int MAX_ROWS = DEF_MAX_ROWS
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        re_i,
  input  logic [$clog2(MAX_ROWS)-1:0] raddr_i,
  input  logic                        we_i,
  input  logic [$clog2(MAX_ROWS)-1:0] waddr_i,
  input  logic [MAX_COLS-1:0]         wdata_i,
  output logic [MAX_COLS-1:0]         rdata_o
);

  logic [MAX_COLS-1:0] mem [MAX_ROWS];
  logic [MAX_COLS-1:0] rdata_q;
  logic [MAX_ROWS-1:0] valid_q;
  logic                rvalid_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rvalid_q <= 1'b0;
    end else begin
      if (we_i) begin
        valid_q[waddr_i] <= 1'b1;
      end
      if (re_i) begin
        rvalid_q <= valid_q[raddr_i];
      end
    end
  end

  // rows never written read as dead
  assign rdata_o = rvalid_q ? rdata_q : '0;

endmodule

// ===== sv/tlg_row_update.sv =====
// Next-generation value of one row from the rows above, at and below it.
`timescale 1ns / 1ps
module tlg_row_update
  import tlg_pkg::*;
#(
  parameter int MAX_COLS = DEF_MAX_COLS
) (
  input  logic [MAX_COLS-1:0]           prev_i,
  input  logic [MAX_COLS-1:0]           cur_i,
  input  logic [MAX_COLS-1:0]           below_i,
  input  logic [$clog2(MAX_COLS+1)-1:0] width_i,
  output logic [MAX_COLS-1:0]           row_o
);

  localparam int CWW = $clog2(MAX_COLS + 1);
  localparam int CAW = $clog2(MAX_COLS);

  logic [CWW-1:0] wm1_full;
  logic [CAW-1:0] wm1;

  assign wm1_full = width_i - CWW'(1);
  assign wm1      = wm1_full[CAW-1:0];

  genvar x;
  for (x = 0; x < MAX_COLS; x++) begin : g_col
    logic [2:0]       lft;
    logic [2:0]       rgt;
    logic [NBR_W-1:0] cnt;
    logic             nxt;

    if (x == 0) begin : g_l
      assign lft = {prev_i[wm1], cur_i[wm1], below_i[wm1]};
    end else begin : g_l
      assign lft = {prev_i[x-1], cur_i[x-1], below_i[x-1]};
    end

    if (x == MAX_COLS - 1) begin : g_r
      assign rgt = {prev_i[0], cur_i[0], below_i[0]};
    end else begin : g_r
      assign rgt = (CAW'(x) == wm1) ? {prev_i[0], cur_i[0], below_i[0]}
                                    : {prev_i[x+1], cur_i[x+1], below_i[x+1]};
    end

    assign cnt = NBR_W'(lft[0]) + NBR_W'(lft[1]) + NBR_W'(lft[2])
               + NBR_W'(rgt[0]) + NBR_W'(rgt[1]) + NBR_W'(rgt[2])
               + NBR_W'(prev_i[x]) + NBR_W'(below_i[x]);

    assign nxt = (cnt == BIRTH_COUNT) || ((cnt == SURVIVE_COUNT) && cur_i[x]);

    // columns outside the active width keep their value
    assign row_o[x] = (CWW'(x) < width_i) ? nxt : cur_i[x];
  end

endmodule

// ===== sv/toroidal_life_generation.sv =====
// Top level of the toroidal life grid: command decode, sweep sequencer, config.
`timescale 1ns / 1ps
// A command is taken when start_i is high and busy_o is low; every command
// gives one result word, shown for one cycle with done_o high, which the
// receiver must take then. A cell write passes through a read-modify-write
// state and a read through a read state; an out-of-range write or read and
// func 3 are answered from idle, and a generation sweeps one row per cycle
// through the single read port of the row memory, after the states that
// load the last row, the first row and the second row. The grid reads as all
// dead after reset with no clearing pass. Size registers are taken at any
// time but must only change while the block is idle.
module toroidal_life_generation
  import tlg_pkg::*;
#(
  parameter int MAX_COLS = DEF_MAX_COLS,
  parameter int MAX_ROWS = DEF_MAX_ROWS
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  output logic                 busy_o,
  input  logic [FUNC_W-1:0]    func_i,
  input  logic [ROW_W-1:0]     row_i,
  input  logic [COL_W-1:0]     col_i,
  input  logic                 cell_in_i,
  output logic                 done_o,
  output logic [FUNC_W-1:0]    op_echo_o,
  output logic                 cell_out_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_W-1:0]     cfg_data_i
);

  localparam int AW  = $clog2(MAX_ROWS);
  localparam int CAW = $clog2(MAX_COLS);
  localparam int CWW = $clog2(MAX_COLS + 1);
  localparam int RWW = $clog2(MAX_ROWS + 1);

  state_e state_q, state_d;

  logic [CFG_W-1:0]    grid_width_q, grid_height_q;
  logic [CWW-1:0]      w_eff;
  logic [RWW-1:0]      h_eff;
  logic [RWW-1:0]      hm1_full;
  logic [AW-1:0]       hm1;
  logic                in_grid;

  logic [AW-1:0]       y_q;
  logic [AW:0]         y_ahead;
  logic                last_row;
  logic [AW-1:0]       row_q;
  logic [CAW-1:0]      col_q;
  logic                val_q;
  logic [FUNC_W-1:0]   op_q;
  logic                done_q, done_d;
  logic                cell_q, cell_d;

  logic [MAX_COLS-1:0] prev_q, cur_q, first_q;
  logic [MAX_COLS-1:0] below;
  logic [MAX_COLS-1:0] row_next;
  logic [MAX_COLS-1:0] rdata;

  logic                re;
  logic [AW-1:0]       raddr;
  logic                we;
  logic [AW-1:0]       waddr;
  logic [MAX_COLS-1:0] wdata;

  logic                accept;

  // effective sizes: zero acts as one, oversize clamps
  always_comb begin
    if (grid_width_q == '0) begin
      w_eff = CWW'(1);
    end else if (32'(grid_width_q) > MAX_COLS) begin
      w_eff = CWW'(MAX_COLS);
    end else begin
      w_eff = CWW'(grid_width_q);
    end
    if (grid_height_q == '0) begin
      h_eff = RWW'(1);
    end else if (32'(grid_height_q) > MAX_ROWS) begin
      h_eff = RWW'(MAX_ROWS);
    end else begin
      h_eff = RWW'(grid_height_q);
    end
  end

  assign hm1_full = h_eff - RWW'(1);
  assign hm1      = hm1_full[AW-1:0];
  assign in_grid  = (32'(row_i) < 32'(h_eff)) && (32'(col_i) < 32'(w_eff));
  assign accept   = start_i && (state_q == ST_IDLE);
  assign last_row = (y_q == hm1);
  assign y_ahead  = {1'b0, y_q} + (AW+1)'(2);
  assign below    = last_row ? first_q : rdata;

  tlg_row_mem #(
    .MAX_COLS (MAX_COLS),
    .MAX_ROWS (MAX_ROWS)
  ) u_mem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .re_i    (re),
    .raddr_i (raddr),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .rdata_o (rdata)
  );

  tlg_row_update #(
    .MAX_COLS (MAX_COLS)
  ) u_update (
    .prev_i  (prev_q),
    .cur_i   (cur_q),
    .below_i (below),
    .width_i (w_eff),
    .row_o   (row_next)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          unique case (func_i)
            FUNC_WRITE: state_d = in_grid ? ST_RMW : ST_IDLE;
            FUNC_STEP:  state_d = ST_LD_PREV;
            FUNC_READ:  state_d = in_grid ? ST_READ : ST_IDLE;
            default:    state_d = ST_IDLE;
          endcase
        end
      end
      ST_RMW:      state_d = ST_IDLE;
      ST_READ:     state_d = ST_IDLE;
      ST_LD_PREV:  state_d = ST_LD_FIRST;
      ST_LD_FIRST: state_d = ST_LD_CUR;
      ST_LD_CUR:   state_d = ST_SWEEP;
      ST_SWEEP:    state_d = last_row ? ST_IDLE : ST_SWEEP;
      default:     state_d = ST_IDLE;
    endcase
  end

  // outputs: memory control and result word
  always_comb begin
    re     = 1'b0;
    raddr  = '0;
    we     = 1'b0;
    waddr  = '0;
    wdata  = rdata;
    done_d = 1'b0;
    cell_d = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        re     = start_i;
        raddr  = AW'(row_i);
        done_d = start_i && (state_d == ST_IDLE);
      end
      ST_RMW: begin
        we           = 1'b1;
        waddr        = row_q;
        wdata[col_q] = val_q;
        done_d       = 1'b1;
      end
      ST_READ: begin
        cell_d = rdata[col_q];
        done_d = 1'b1;
      end
      ST_LD_PREV: begin
        re    = 1'b1;
        raddr = hm1;
      end
      ST_LD_FIRST: begin
        re    = 1'b1;
        raddr = '0;
      end
      ST_LD_CUR: begin
        re    = 1'b1;
        raddr = AW'(1);
      end
      ST_SWEEP: begin
        re     = !last_row;
        raddr  = (32'(y_ahead) < MAX_ROWS) ? y_ahead[AW-1:0] : '0;
        we     = 1'b1;
        waddr  = y_q;
        wdata  = row_next;
        done_d = last_row;
      end
      default: begin
        re = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      done_q        <= 1'b0;
      grid_width_q  <= CFG_SIZE_RESET;
      grid_height_q <= CFG_SIZE_RESET;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          CFG_GRID_WIDTH:  grid_width_q  <= cfg_data_i;
          CFG_GRID_HEIGHT: grid_height_q <= cfg_data_i;
          default:         grid_width_q  <= grid_width_q;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cell_q <= cell_d;
    if (accept) begin
      op_q  <= func_i;
      row_q <= AW'(row_i);
      col_q <= CAW'(col_i);
      val_q <= cell_in_i;
    end
    unique case (state_q)
      ST_LD_FIRST: prev_q <= rdata;
      ST_LD_CUR: begin
        first_q <= rdata;
        cur_q   <= rdata;
        y_q     <= '0;
      end
      ST_SWEEP: begin
        prev_q <= cur_q;
        cur_q  <= below;
        y_q    <= y_q + AW'(1);
      end
      default: begin
        prev_q <= prev_q;
      end
    endcase
  end

  assign busy_o      = (state_q != ST_IDLE);
  assign cfg_ready_o = 1'b1;
  assign done_o      = done_q;
  assign op_echo_o   = op_q;
  assign cell_out_o  = cell_q;

endmodule

// ===== verif/testbench.sv =====
// Self-checking testbench for the toroidal life grid: directed and random commands.
`timescale 1ns / 1ps
module testbench;
  import tlg_pkg::*;

  localparam logic [FUNC_W-1:0] FUNC_NONE = 2'd3;
  localparam int GRID_MAX = 64;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int RANDOM_PHASES = 21;
  localparam int PHASE_WORDS = 88;

  typedef struct {
    logic [FUNC_W-1:0] op;
    logic              cell_val;
  } word_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 start_i = 1'b0;
  logic                 busy_o;
  logic [FUNC_W-1:0]    func_i = FUNC_WRITE;
  logic [ROW_W-1:0]     row_i = '0;
  logic [COL_W-1:0]     col_i = '0;
  logic                 cell_in_i = 1'b0;
  logic                 done_o;
  logic [FUNC_W-1:0]    op_echo_o;
  logic                 cell_out_o;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = CFG_GRID_WIDTH;
  logic [CFG_W-1:0]     cfg_data_i = '0;

  logic [GRID_MAX-1:0] grid_model [GRID_MAX];
  logic [CFG_W-1:0]    width_reg;
  logic [CFG_W-1:0]    height_reg;
  word_t               expected_words [$];
  int                  mismatches = 0;
  int                  cycle_count = 0;
  int                  max_gap = 5;

  toroidal_life_generation dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .busy_o      (busy_o),
    .func_i      (func_i),
    .row_i       (row_i),
    .col_i       (col_i),
    .cell_in_i   (cell_in_i),
    .done_o      (done_o),
    .op_echo_o   (op_echo_o),
    .cell_out_o  (cell_out_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic int unsigned eff_size(input logic [CFG_W-1:0] v, input int unsigned maxv);
    if (v == '0) return 1;
    if (32'(v) > maxv) return maxv;
    return 32'(v);
  endfunction

  // all cells update from an old-grid snapshot; small sizes count wrapped cells twice or more
  task automatic next_generation();
    logic [GRID_MAX-1:0] old_grid [GRID_MAX];
    int unsigned w, h, n;
    old_grid = grid_model;
    w = eff_size(width_reg, GRID_MAX);
    h = eff_size(height_reg, GRID_MAX);
    for (int unsigned y = 0; y < h; y++) begin
      for (int unsigned x = 0; x < w; x++) begin
        n = 0;
        for (int unsigned dy = 0; dy < 3; dy++) begin
          for (int unsigned dx = 0; dx < 3; dx++) begin
            n += 32'(old_grid[(y + h - 1 + dy) % h][(x + w - 1 + dx) % w]);
          end
        end
        n -= 32'(old_grid[y][x]);
        grid_model[y][x] = (n == 3) || (n == 2 && old_grid[y][x]);
      end
    end
  endtask

  task automatic apply_command(input logic [FUNC_W-1:0] f, input logic [ROW_W-1:0] r,
                               input logic [COL_W-1:0] c, input logic v);
    word_t       res;
    logic        on_grid;
    on_grid = (32'(r) < eff_size(height_reg, GRID_MAX))
           && (32'(c) < eff_size(width_reg, GRID_MAX));
    res.op = f;
    res.cell_val = 1'b0;
    if (f == FUNC_WRITE) begin
      if (on_grid) grid_model[r][c] = v;
    end else if (f == FUNC_STEP) begin
      next_generation();
    end else if (f == FUNC_READ) begin
      if (on_grid) res.cell_val = grid_model[r][c];
    end
    expected_words.push_back(res);
  endtask

  // start_i stays high on return so a back-to-back word need not drop and raise it again
  task automatic send_cmd(input logic [FUNC_W-1:0] f, input logic [ROW_W-1:0] r,
                          input logic [COL_W-1:0] c, input logic v);
    int gap;
    gap = $urandom_range(0, max_gap);
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i <= 1'b1;
    func_i <= f;
    row_i <= r;
    col_i <= c;
    cell_in_i <= v;
    do @(posedge clk_i); while (busy_o !== 1'b0);
    apply_command(f, r, c, v);
  endtask

  task automatic drain();
    start_i <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic program_size(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= CFG_GRID_WIDTH;
    cfg_data_i <= w;
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    width_reg = w;
    cfg_index_i <= CFG_GRID_HEIGHT;
    cfg_data_i <= h;
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    height_reg = h;
    cfg_valid_i <= 1'b0;
  endtask

  always @(posedge clk_i) begin : check_words
    word_t want;
    if (rst_ni && done_o === 1'b1) begin
      if (expected_words.size() == 0) begin
        $display("%0t: unexpected word op_echo %0d cell_out %0d", $time, op_echo_o, cell_out_o);
        mismatches++;
      end else begin
        want = expected_words.pop_front();
        if (op_echo_o !== want.op) begin
          $display("%0t: op_echo expected %0d got %0d", $time, want.op, op_echo_o);
          mismatches++;
        end
        if (cell_out_o !== want.cell_val) begin
          $display("%0t: cell_out expected %0d got %0d", $time, want.cell_val, cell_out_o);
          mismatches++;
        end
      end
    end
  end

  task automatic test_reset_state();
    send_cmd(FUNC_READ, 6'd0, 6'd0, 1'b0);
    send_cmd(FUNC_READ, 6'd29, 6'd29, 1'b0);
    send_cmd(FUNC_READ, 6'd63, 6'd63, 1'b0);
  endtask

  task automatic test_cell_access();
    send_cmd(FUNC_WRITE, 6'd0, 6'd0, 1'b1);
    send_cmd(FUNC_WRITE, 6'd29, 6'd29, 1'b1);
    send_cmd(FUNC_WRITE, 6'd63, 6'd63, 1'b1);
    send_cmd(FUNC_READ, 6'd0, 6'd0, 1'b0);
    send_cmd(FUNC_READ, 6'd29, 6'd29, 1'b0);
    send_cmd(FUNC_NONE, 6'd63, 6'd63, 1'b1);
    send_cmd(FUNC_READ, 6'd63, 6'd63, 1'b0);
  endtask

  // blinker straddling the column wrap, then flipped across the row wrap
  task automatic test_wrapped_blinker();
    send_cmd(FUNC_WRITE, 6'd29, 6'd29, 1'b0);
    send_cmd(FUNC_WRITE, 6'd0, 6'd29, 1'b1);
    send_cmd(FUNC_WRITE, 6'd0, 6'd1, 1'b1);
    send_cmd(FUNC_STEP, 6'd0, 6'd0, 1'b0);
    send_cmd(FUNC_READ, 6'd29, 6'd0, 1'b0);
    send_cmd(FUNC_READ, 6'd1, 6'd0, 1'b0);
    send_cmd(FUNC_READ, 6'd0, 6'd29, 1'b0);
    send_cmd(FUNC_STEP, 6'd0, 6'd0, 1'b0);
    send_cmd(FUNC_READ, 6'd0, 6'd1, 1'b0);
  endtask

  // full size, zero size (acts as one cell) and oversize (clamped to full)
  task automatic test_size_extremes();
    drain();
    program_size(7'd64, 7'd64);
    send_cmd(FUNC_WRITE, 6'd63, 6'd63, 1'b1);
    send_cmd(FUNC_READ, 6'd63, 6'd63, 1'b0);
    drain();
    program_size(7'd0, 7'd0);
    send_cmd(FUNC_WRITE, 6'd0, 6'd0, 1'b1);
    send_cmd(FUNC_STEP, 6'd0, 6'd0, 1'b0);
    send_cmd(FUNC_READ, 6'd0, 6'd0, 1'b0);
    drain();
    program_size(7'd127, 7'd127);
    send_cmd(FUNC_READ, 6'd63, 6'd63, 1'b0);
  endtask

  function automatic logic [CFG_W-1:0] pick_size();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) begin
      case ($urandom_range(0, 3))
        0: return 7'd0;
        1: return 7'd1;
        2: return 7'd64;
        default: return 7'd127;
      endcase
    end
    if (sel <= 5) return CFG_W'($urandom_range(1, 8));
    if (sel <= 8) return CFG_W'($urandom_range(9, 40));
    return CFG_W'($urandom_range(41, 127));
  endfunction

  task automatic random_cmd();
    int          pick;
    int unsigned w, h;
    logic [ROW_W-1:0] r;
    logic [COL_W-1:0] c;
    w = eff_size(width_reg, GRID_MAX);
    h = eff_size(height_reg, GRID_MAX);
    r = ROW_W'($urandom_range(0, h - 1));
    c = COL_W'($urandom_range(0, w - 1));
    pick = $urandom_range(0, 99);
    if (pick < 10) begin
      if (h < GRID_MAX) r = ROW_W'($urandom_range(h, GRID_MAX - 1));
      if (w < GRID_MAX && $urandom_range(0, 1)) c = COL_W'($urandom_range(w, GRID_MAX - 1));
      send_cmd($urandom_range(0, 1) ? FUNC_WRITE : FUNC_READ, r, c, 1'($urandom_range(0, 1)));
    end else if (pick < 14) begin
      send_cmd(FUNC_NONE, ROW_W'($urandom_range(0, 63)), COL_W'($urandom_range(0, 63)),
               1'($urandom_range(0, 1)));
    end else if (pick < 38) begin
      send_cmd(FUNC_WRITE, r, c, 1'($urandom_range(0, 1)));
    end else if (pick < 58) begin
      send_cmd(FUNC_STEP, ROW_W'($urandom_range(0, 63)), COL_W'($urandom_range(0, 63)),
               1'($urandom_range(0, 1)));
    end else begin
      send_cmd(FUNC_READ, r, c, 1'($urandom_range(0, 1)));
    end
  endtask

  // each phase: new size, a seeded pattern, then a mix of writes, generations, reads and noise
  task automatic test_random_phases();
    int seeds;
    int unsigned w, h;
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      drain();
      program_size(pick_size(), pick_size());
      max_gap = $urandom_range(0, 1) ? 5 : 0;
      w = eff_size(width_reg, GRID_MAX);
      h = eff_size(height_reg, GRID_MAX);
      seeds = $urandom_range(3, 20);
      for (int i = 0; i < seeds; i++) begin
        send_cmd(FUNC_WRITE, ROW_W'($urandom_range(0, h - 1)), COL_W'($urandom_range(0, w - 1)),
                 $urandom_range(0, 9) < 7);
      end
      for (int i = seeds; i < PHASE_WORDS; i++) random_cmd();
    end
  endtask

  initial begin
    for (int i = 0; i < GRID_MAX; i++) grid_model[i] = '0;
    width_reg = CFG_SIZE_RESET;
    height_reg = CFG_SIZE_RESET;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_state();
    test_cell_access();
    test_wrapped_blinker();
    test_size_extremes();
    test_random_phases();
    drain();
    repeat (80) @(posedge clk_i);
    if (mismatches == 0 && expected_words.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/tlg_pkg.sv
sv/tlg_row_mem.sv
sv/tlg_row_update.sv
sv/toroidal_life_generation.sv
verif/testbench.sv
